### design/overlapping_frame_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for overlapping_frame_deframer_top
// Concurrent checks clocked on clk, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef OVERLAPPING_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define OVERLAPPING_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define OFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked also while reset is high
`define OFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OFD_ASSERT(lbl, prop, msg)
`define OFD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### design/ofd_pkg.sv
// ----------------------------------------------------------------------------
// ofd_pkg
// Types and constants of the overlapping frame deframer.
// ----------------------------------------------------------------------------
package ofd_pkg;

  localparam int CANDIDATES  = 8;
  localparam int SLOT_W      = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
  localparam int CNT_W       = $clog2(CANDIDATES + 1);
  localparam int BUFFER_SIZE = 1024;
  localparam int RING_W      = $clog2(BUFFER_SIZE);
  localparam int PROG_W      = 17;

  localparam logic [7:0]  RESET_HEADER_HIGH = 8'hA5;
  localparam logic [7:0]  RESET_HEADER_LOW  = 8'h5A;
  localparam logic [15:0] RESET_MAX_PAYLOAD = 16'd1024;
  localparam logic [7:0]  RESET_OWN_ADDRESS = 8'h04;

  localparam logic [RING_W-1:0] PAYLOAD_OFFSET = RING_W'(8);

  typedef enum logic [1:0] {
    REG_HEADER_HIGH = 2'd0,
    REG_HEADER_LOW  = 2'd1,
    REG_MAX_PAYLOAD = 2'd2,
    REG_OWN_ADDRESS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_LEN_ERR = 2'd1,
    STATUS_SUM_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        source_addr;
    logic [7:0]        dest_addr;
    logic              for_this_node;
    logic [15:0]       command;
    logic [15:0]       payload_len;
    logic [RING_W-1:0] frame_start;
    logic [RING_W-1:0] payload_start;
    logic [15:0]       sum_received;
    logic [15:0]       sum_computed;
    logic              last;
  } result_t;

endpackage

### design/ofd_if.sv
// ----------------------------------------------------------------------------
// ofd_in_if / ofd_out_if
// Valid/ready channels for received bytes and completed frame results.
// ----------------------------------------------------------------------------
interface ofd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ofd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  source_addr;
  logic [7:0]  dest_addr;
  logic        for_this_node;
  logic [15:0] command;
  logic [15:0] payload_len;
  logic [9:0]  frame_start;
  logic [9:0]  payload_start;
  logic [15:0] sum_received;
  logic [15:0] sum_computed;
  logic        last;

  modport source (output valid, output status, output source_addr, output dest_addr,
                  output for_this_node, output command, output payload_len,
                  output frame_start, output payload_start, output sum_received,
                  output sum_computed, output last, input ready);
  modport sink   (input valid, input status, input source_addr, input dest_addr,
                  input for_this_node, input command, input payload_len,
                  input frame_start, input payload_start, input sum_received,
                  input sum_computed, input last, output ready);
endinterface

### design/overlapping_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// overlapping_frame_deframer_top
// Tracks overlapping length-prefixed frames and reports each completed one.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  rx        in   valid/ready    rx_byte
//  res       out  valid/ready    status, addresses, command, length, sum, last
//  cfg       in   cfg_we         cfg_index, cfg_wdata
//
//  a byte is accepted in the idle state, then each open candidate (up to
//  eight) passes in turn through the shared slot update unit, and a finish
//  step closes the byte; rx.ready is high only when idle
//  a full result register stalls the slot scan while a second result waits
//  synchronous reset empties the candidate list and zeroes the ring position
`include "overlapping_frame_deframer_top_assert.svh"

module overlapping_frame_deframer_top
  import ofd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ofd_in_if.sink      rx,
  ofd_out_if.source   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration
  logic [7:0]  header_high;
  logic [7:0]  header_low;
  logic [15:0] max_payload;
  logic [7:0]  own_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_high <= RESET_HEADER_HIGH;
      header_low  <= RESET_HEADER_LOW;
      max_payload <= RESET_MAX_PAYLOAD;
      own_address <= RESET_OWN_ADDRESS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_HIGH: header_high <= cfg_wdata[7:0];
        REG_HEADER_LOW:  header_low  <= cfg_wdata[7:0];
        REG_MAX_PAYLOAD: max_payload <= cfg_wdata;
        REG_OWN_ADDRESS: own_address <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // candidate slots, open ones packed at the low indexes
  logic [PROG_W-1:0] slot_progress  [CANDIDATES];
  logic [15:0]       slot_length    [CANDIDATES];
  logic [15:0]       slot_sum       [CANDIDATES];
  logic [15:0]       slot_addresses [CANDIDATES];
  logic [15:0]       slot_command   [CANDIDATES];
  logic [15:0]       slot_trailer   [CANDIDATES];
  logic [RING_W-1:0] slot_start     [CANDIDATES];

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] scan_idx;
  logic [CNT_W-1:0]  wr_cnt;
  logic [RING_W-1:0] ring_position;
  logic [7:0]        cur_byte;

  logic    out_valid;
  result_t out_data;
  logic    pend_valid;
  result_t pend_data;

  // shared slot update unit
  logic [PROG_W-1:0] p;
  logic [PROG_W-1:0] len_ext;
  logic [15:0]       new_length, new_sum, new_addr, new_command, new_trailer;
  logic              keep, complete;
  result_t           cmp_res;

  always_comb begin
    p           = slot_progress[scan_idx] + PROG_W'(1);
    len_ext     = PROG_W'(slot_length[scan_idx]);
    new_length  = slot_length[scan_idx];
    new_sum     = slot_sum[scan_idx];
    new_addr    = slot_addresses[scan_idx];
    new_command = slot_command[scan_idx];
    new_trailer = slot_trailer[scan_idx];
    keep        = 1'b1;
    complete    = 1'b0;
    priority if (p == PROG_W'(2)) begin
      keep = (cur_byte == header_low);
    end else if (p == PROG_W'(3)) begin
      new_addr[15:8] = cur_byte;
    end else if (p == PROG_W'(4)) begin
      new_addr[7:0] = cur_byte;
    end else if (p == PROG_W'(5)) begin
      new_command = {cur_byte, 8'h00};
    end else if (p == PROG_W'(6)) begin
      new_command[7:0] = cur_byte;
    end else if (p == PROG_W'(7)) begin
      new_length = {cur_byte, 8'h00};
    end else if (p == PROG_W'(8)) begin
      new_length[7:0] = cur_byte;
    end else if (p <= len_ext + PROG_W'(8)) begin
      new_sum = new_sum + {8'h00, cur_byte};
    end else if (p == len_ext + PROG_W'(9)) begin
      new_trailer = {cur_byte, 8'h00};
    end else begin
      new_trailer[7:0] = cur_byte;
      complete         = 1'b1;
      keep             = 1'b0;
    end

    if (new_length > max_payload) begin
      cmp_res.status = STATUS_LEN_ERR;
    end else if (new_trailer != new_sum) begin
      cmp_res.status = STATUS_SUM_ERR;
    end else begin
      cmp_res.status = STATUS_OK;
    end
    cmp_res.source_addr   = new_addr[15:8];
    cmp_res.dest_addr     = new_addr[7:0];
    cmp_res.for_this_node = (new_addr[7:0] == own_address);
    cmp_res.command       = new_command;
    cmp_res.payload_len   = new_length;
    cmp_res.frame_start   = slot_start[scan_idx];
    cmp_res.payload_start = slot_start[scan_idx] + PAYLOAD_OFFSET;
    cmp_res.sum_received  = new_trailer;
    cmp_res.sum_computed  = new_sum;
    cmp_res.last          = 1'b0;
  end

  // sequencer control
  logic rx_accept, out_free, scan_last, scan_go, finish_go, out_load;
  logic open_new;
  result_t out_load_data;

  assign rx_accept = rx.valid && rx.ready;
  assign out_free  = !out_valid || res.ready;
  assign scan_last = ({1'b0, scan_idx} == CNT_W'(count - CNT_W'(1)));
  assign open_new  = (cur_byte == header_high) && (wr_cnt < CNT_W'(CANDIDATES));

  always_comb begin
    state_next    = state;
    rx.ready      = 1'b0;
    scan_go       = 1'b0;
    finish_go     = 1'b0;
    out_load      = 1'b0;
    out_load_data = pend_data;
    unique case (state)
      ST_IDLE: begin
        rx.ready = 1'b1;
        if (rx.valid) begin
          state_next = (count == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a second completion needs the older one moved out first
        scan_go = !(complete && pend_valid && !out_free);
        if (scan_go && complete && pend_valid) begin
          out_load = 1'b1;
        end
        if (scan_go && scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish_go = !pend_valid || out_free;
        if (pend_valid && out_free) begin
          out_load           = 1'b1;
          out_load_data.last = 1'b1;
        end
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      scan_idx      <= '0;
      wr_cnt        <= '0;
      ring_position <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !res.ready);
      if (rx_accept) begin
        scan_idx <= '0;
        wr_cnt   <= '0;
      end
      if (scan_go) begin
        scan_idx <= scan_idx + SLOT_W'(1);
        if (keep) begin
          wr_cnt <= wr_cnt + CNT_W'(1);
        end
        if (complete) begin
          pend_valid <= 1'b1;
        end
      end
      if (finish_go) begin
        pend_valid    <= 1'b0;
        ring_position <= ring_position + RING_W'(1);
        count         <= open_new ? wr_cnt + CNT_W'(1) : wr_cnt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rx_accept) begin
      cur_byte <= rx.rx_byte;
    end
    if (out_load) begin
      out_data <= out_load_data;
    end
    if (scan_go && complete) begin
      pend_data <= cmp_res;
    end
    if (scan_go && keep) begin
      slot_progress[wr_cnt[SLOT_W-1:0]]  <= p;
      slot_length[wr_cnt[SLOT_W-1:0]]    <= new_length;
      slot_sum[wr_cnt[SLOT_W-1:0]]       <= new_sum;
      slot_addresses[wr_cnt[SLOT_W-1:0]] <= new_addr;
      slot_command[wr_cnt[SLOT_W-1:0]]   <= new_command;
      slot_trailer[wr_cnt[SLOT_W-1:0]]   <= new_trailer;
      slot_start[wr_cnt[SLOT_W-1:0]]     <= slot_start[scan_idx];
    end
    if (finish_go && open_new) begin
      slot_progress[wr_cnt[SLOT_W-1:0]] <= PROG_W'(1);
      slot_length[wr_cnt[SLOT_W-1:0]]   <= '0;
      slot_sum[wr_cnt[SLOT_W-1:0]]      <= '0;
      slot_start[wr_cnt[SLOT_W-1:0]]    <= ring_position;
    end
  end

  assign res.valid         = out_valid;
  assign res.status        = out_data.status;
  assign res.source_addr   = out_data.source_addr;
  assign res.dest_addr     = out_data.dest_addr;
  assign res.for_this_node = out_data.for_this_node;
  assign res.command       = out_data.command;
  assign res.payload_len   = out_data.payload_len;
  assign res.frame_start   = out_data.frame_start;
  assign res.payload_start = out_data.payload_start;
  assign res.sum_received  = out_data.sum_received;
  assign res.sum_computed  = out_data.sum_computed;
  assign res.last          = out_data.last;

  `OFD_ASSERT(a_count_bound, count <= CNT_W'(CANDIDATES), "open candidate count overflow")
  `OFD_ASSERT(a_compact_order, (state == ST_SCAN) |-> (wr_cnt <= {1'b0, scan_idx}), "slot write passes read")
  `OFD_ASSERT(a_ring_step, finish_go |=> (ring_position == $past(ring_position) + RING_W'(1)), "ring position skipped")
  `OFD_ASSERT_RST(a_reset_state, rst |=> (state == ST_IDLE && count == '0 && !out_valid), "reset left state")

endmodule
